// File: design/twg_pkg.sv
// Shared types, constants and the quarter-wave sine table of the waveform generator.
package twg_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int SINE_DEPTH = 256;
  localparam int SINE_BITS  = 8;

  // Remainder steps, one per integer bit of the output sum
  localparam int DIV_STEPS  = 28;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Shared multiplier operand widths
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic               en;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef enum logic [2:0] {
    WAVE_LINEAR   = 3'd0,
    WAVE_SINE     = 3'd1,
    WAVE_SQUARE   = 3'd2,
    WAVE_SAW      = 3'd3,
    WAVE_TRIANGLE = 3'd4,
    WAVE_HOVER    = 3'd5
  } wave_e;

  typedef enum logic [2:0] {
    REG_MODE        = 3'd0,
    REG_AMPLITUDE   = 3'd1,
    REG_START_SPEED = 3'd2,
    REG_ACCEL       = 3'd3,
    REG_OFFSET      = 3'd4,
    REG_PERIODS     = 3'd5,
    REG_START_DELAY = 3'd6,
    REG_QUANT_STEP  = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXP0,
    ST_UPD,
    ST_ACC,
    ST_EXP1,
    ST_EVAL,
    ST_WAVE,
    ST_MLO,
    ST_MHI,
    ST_SUM,
    ST_DIV,
    ST_QFIN,
    ST_OUT
  } state_e;

  typedef logic [FRAC_BITS:0] sine_t;
  typedef sine_t sine_rom_t [0:SINE_DEPTH];

  // Sum the Taylor series of sin up to x^13 in Q30, round to the output format
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      x    = HALF_PI_Q30 * 64'(i) / 64'(SINE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + $signed(term);
      if (sum < 0) begin
        sum = 0;
      end
      rom[i] = sine_t'((sum + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// File: design/tick_driven_waveform_generator_unit.sv
// An accepted item runs through the sequencer states in order; when
// quant_step is nonzero a bit-serial remainder stage follows the sum.
// No new item is taken until the result of the last one is taken; one
// shared 32x24 multiplier carries all products of the sequencer steps.
// Reset: configuration takes its default values, phase timer clears, speed
// resets to its default start speed and the remaining delay clears.
module tick_driven_waveform_generator_unit import twg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,  // tick_dt[15:0], enabled, pointer_inside, current_value[31:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // value[31:0], write_value, delay_ended, expired
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i
);

  function automatic logic signed [31:0] sat32(input logic signed [44:0] v);
    logic signed [31:0] r;
    if (v > 45'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -45'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  state_e state_q, state_d;

  // Configuration
  logic [3:0]         mode_q;
  logic signed [31:0] amp_q;
  logic signed [23:0] accel_q;
  logic signed [31:0] offset_q;
  logic signed [23:0] periods_q;
  logic [15:0]        quant_q;

  // Animation state
  logic [31:0]        timer_q, timer_d;
  logic signed [23:0] speed_q, speed_d;
  logic signed [32:0] delay_q, delay_d;

  // Item and working registers
  logic [15:0]        dt_q;
  logic               en_q, ptr_q;
  logic signed [31:0] cur_q;
  logic               before_q, before_d;
  logic               ended_q, ended_d;
  logic               moving_q, moving_d;
  logic [15:0]        dteff_q, dteff_d;
  logic               pend_q, pend_d;
  logic               expt_q, expt_d;
  logic               expout_q, expout_d;
  logic               write_q, write_d;
  logic signed [40:0] p_q, p_d;
  logic [39:0]        xmag_q, xmag_d;
  logic               xneg_q, xneg_d;
  logic [MUL_P_W-1:0] lo_q, lo_d;
  logic signed [43:0] sum_q, sum_d;
  logic [27:0]        div_q, div_d;
  logic [15:0]        rem_q, rem_d;
  logic [4:0]         cnt_q, cnt_d;
  logic signed [31:0] value_q, value_d;

  mul_req_t           mul_req;
  logic [MUL_P_W-1:0] prod;

  twg_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  logic               in_fire;
  logic [2:0]         wave;
  logic [23:0]        speed_mag, accel_mag;
  logic [31:0]        amag;
  logic               prod_gt_periods;
  logic signed [56:0] prod_speed_s;
  logic signed [56:0] prod_accel_s;

  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign wave            = mode_q[2:0];
  assign speed_mag       = speed_q[23] ? 24'(-speed_q) : 24'(speed_q);
  assign accel_mag       = accel_q[23] ? 24'(-accel_q) : 24'(accel_q);
  assign amag            = amp_q[31] ? 32'(-amp_q) : 32'(amp_q);
  assign prod_gt_periods = !periods_q[23] && (prod > MUL_P_W'({periods_q[22:0], 16'b0}));
  assign prod_speed_s    = speed_q[23] ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
  assign prod_accel_s    = accel_q[23] ? -$signed({1'b0, prod}) : $signed({1'b0, prod});

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_EXP0;
      ST_EXP0: state_d = ST_UPD;
      ST_UPD:  state_d = ST_ACC;
      ST_ACC:  state_d = ST_EXP1;
      ST_EXP1: state_d = ST_EVAL;
      ST_EVAL: state_d = ST_WAVE;
      ST_WAVE: state_d = ST_MLO;
      ST_MLO:  state_d = ST_MHI;
      ST_MHI:  state_d = ST_SUM;
      ST_SUM:  state_d = (quant_q == 16'd0) ? ST_OUT : ST_DIV;
      ST_DIV:  if (cnt_q == 5'(DIV_STEPS - 1)) state_d = ST_QFIN;
      ST_QFIN: state_d = ST_OUT;
      ST_OUT:  if (m_axis_tready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    m_axis_tvalid_o = (state_q == ST_OUT);
    cfg_ready_o     = 1'b1;
    m_axis_tdata_o  = {5'b0, expout_q, ended_q, write_q, value_q};
  end

  // Datapath steps
  always_comb begin
    logic signed [33:0] dsub;
    logic [32:0]        tsum;
    logic signed [40:0] step;
    logic signed [41:0] spsum;
    logic               act_after;
    logic [15:0]        f;
    logic [9:0]         n;
    logic [8:0]         idx;
    logic signed [18:0] wv;
    logic [71:0]        big;
    logic [55:0]        shv;
    logic [40:0]        wmag;
    logic signed [43:0] w;
    logic signed [43:0] t;
    logic signed [43:0] amag_s;
    logic [16:0]        remsh;
    logic [15:0]        fmod;
    logic signed [28:0] qv;

    timer_d  = timer_q;
    speed_d  = speed_q;
    delay_d  = delay_q;
    before_d = before_q;
    ended_d  = ended_q;
    moving_d = moving_q;
    dteff_d  = dteff_q;
    pend_d   = pend_q;
    expt_d   = expt_q;
    expout_d = expout_q;
    write_d  = write_q;
    p_d      = p_q;
    xmag_d   = xmag_q;
    xneg_d   = xneg_q;
    lo_d     = lo_q;
    sum_d    = sum_q;
    div_d    = div_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    value_d  = value_q;
    mul_req  = '0;

    dsub = '0; tsum = '0; step = '0; spsum = '0; act_after = 1'b0;
    f = p_q[15:0]; n = f[FRAC_BITS-1 -: SINE_BITS+2]; idx = '0; wv = '0;
    big = '0; shv = '0; wmag = '0; w = '0; t = '0;
    amag_s = 44'(signed'({1'b0, amag}));
    remsh = '0; fmod = '0; qv = '0;

    case (state_q)
      // Expiry check on the state before the tick
      ST_EXP0: begin
        mul_req = '{en: 1'b1, a: timer_q, b: speed_mag};
      end
      // Count down the delay, advance the timer, start the speed change
      ST_UPD: begin
        before_d = en_q && ((wave == WAVE_HOVER) ||
                            (!(delay_q > 33'sd0) && !prod_gt_periods));
        ended_d  = 1'b0;
        moving_d = en_q;
        dteff_d  = dt_q;
        if (en_q && (delay_q > 33'sd0)) begin
          dsub    = 34'(delay_q) - $signed({18'b0, dt_q});
          delay_d = dsub[32:0];
          if (dsub > 34'sd0) begin
            moving_d = 1'b0;
          end else begin
            ended_d = 1'b1;
            dteff_d = delay_q[15:0];
          end
        end
        if (moving_d) begin
          tsum    = {1'b0, timer_q} + 33'(dteff_d);
          timer_d = tsum[32] ? 32'hffffffff : tsum[31:0];
        end
        mul_req = '{en: 1'b1, a: 32'(dteff_d), b: accel_mag};
      end
      // Apply acceleration, saturated to the speed width
      ST_ACC: begin
        if (moving_q && (accel_q != 24'sd0)) begin
          step  = 41'(prod_accel_s >>> FRAC_BITS);
          spsum = 42'(speed_q) + 42'(step);
          if (spsum > 42'sd8388607) begin
            speed_d = 24'sh7fffff;
          end else if (spsum < -42'sd8388608) begin
            speed_d = 24'sh800000;
          end else begin
            speed_d = spsum[23:0];
          end
        end
      end
      // Phase product on the state after the tick
      ST_EXP1: begin
        mul_req = '{en: 1'b1, a: timer_q, b: speed_mag};
      end
      // Resolve expiry, write flag and phase
      ST_EVAL: begin
        pend_d    = (delay_q > 33'sd0);
        expt_d    = prod_gt_periods;
        expout_d  = !en_q || prod_gt_periods;
        act_after = en_q && ((wave == WAVE_HOVER) || (!pend_d && !prod_gt_periods));
        write_d   = before_q || act_after || ended_q;
        if (prod_gt_periods) begin
          if (speed_q > 24'sd0) begin
            p_d = 41'(periods_q);
          end else if (speed_q < 24'sd0) begin
            p_d = -41'(periods_q);
          end else begin
            p_d = '0;
          end
        end else begin
          p_d = 41'(prod_speed_s >>> FRAC_BITS);
        end
      end
      // Shape the phase into the multiplier operand
      ST_WAVE: begin
        xmag_d = '0;
        xneg_d = 1'b0;
        case (wave)
          WAVE_LINEAR: begin
            xneg_d = p_q[40];
            xmag_d = p_q[40] ? 40'(-p_q) : 40'(p_q);
          end
          WAVE_SINE: begin
            idx    = n[SINE_BITS] ? (9'(SINE_DEPTH) - {1'b0, n[SINE_BITS-1:0]})
                                  : {1'b0, n[SINE_BITS-1:0]};
            xneg_d = n[SINE_BITS+1];
            xmag_d = 40'(SINE_ROM[idx]);
          end
          WAVE_SAW: begin
            wv     = $signed({2'b0, ~f[15], f[14:0], 1'b0}) - 19'sd65536;
            xneg_d = wv[18];
            xmag_d = wv[18] ? 40'(-wv) : 40'(wv);
          end
          WAVE_TRIANGLE: begin
            if ((f < 16'h4000) || (f > 16'hc000)) begin
              wv = $signed({1'b0, ~f[15], f[14:0], 2'b0}) - 19'sd131072;
            end else begin
              wv = 19'sd65536 - $signed({1'b0, 16'(f - 16'h4000), 2'b0});
            end
            xneg_d = wv[18];
            xmag_d = wv[18] ? 40'(-wv) : 40'(wv);
          end
          default: begin
            xmag_d = '0;
          end
        endcase
      end
      // Low partial product, or the hover step
      ST_MLO: begin
        if (wave == WAVE_HOVER) begin
          mul_req = '{en: 1'b1, a: 32'(dteff_q), b: speed_mag};
        end else begin
          mul_req = '{en: 1'b1, a: amag, b: xmag_q[23:0]};
        end
      end
      // High partial product
      ST_MHI: begin
        lo_d = prod;
        if (wave != WAVE_HOVER) begin
          mul_req = '{en: 1'b1, a: amag, b: {8'b0, xmag_q[39:24]}};
        end
      end
      // Form the wave value and add the offset
      ST_SUM: begin
        w = '0;
        if (!(pend_q || (expt_q && mode_q[3]))) begin
          case (wave)
            WAVE_LINEAR, WAVE_SINE, WAVE_SAW, WAVE_TRIANGLE: begin
              big  = 72'(lo_q) + (72'(prod) << 24);
              shv  = big[71:16];
              wmag = (shv > 56'(41'h100_0000_0000)) ? 41'h100_0000_0000 : shv[40:0];
              w    = (xneg_q ^ amp_q[31]) ? -44'(signed'({1'b0, wmag}))
                                         : 44'(signed'({1'b0, wmag}));
            end
            WAVE_SQUARE: begin
              w = (f < 16'h8000) ? 44'(amp_q) : -44'(amp_q);
            end
            WAVE_HOVER: begin
              step = 41'(signed'(lo_q[55:0] >> FRAC_BITS));
              step = speed_q[23] ? 41'((-$signed({1'b0, lo_q})) >>> FRAC_BITS) : step;
              if ((!amp_q[31]) == ptr_q) begin
                t = 44'(cur_q) - 44'(offset_q) + 44'(step);
                w = (t > amag_s) ? amag_s : t;
              end else begin
                t = 44'(cur_q) - 44'(offset_q) - 44'(step);
                w = (t < -amag_s) ? -amag_s : t;
              end
            end
            default: begin
              w = '0;
            end
          endcase
        end
        sum_d   = w + 44'(offset_q);
        value_d = write_q ? sat32(45'(sum_d)) : 32'sd0;
        div_d   = sum_d[43] ? 28'(-sum_d[43:16]) : sum_d[43:16];
        rem_d   = '0;
        cnt_d   = '0;
      end
      // One remainder bit a cycle
      ST_DIV: begin
        remsh = {rem_q, div_q[27]};
        rem_d = (remsh >= {1'b0, quant_q}) ? 16'(remsh - {1'b0, quant_q}) : remsh[15:0];
        div_d = {div_q[26:0], 1'b0};
        cnt_d = cnt_q + 5'd1;
      end
      // Floor to a multiple of the step and saturate
      ST_QFIN: begin
        fmod    = (sum_q[43] && (rem_q != 16'd0)) ? (quant_q - rem_q) : rem_q;
        qv      = 29'($signed(sum_q[43:16])) - $signed({13'b0, fmod});
        value_d = write_q ? sat32({qv, 16'b0}) : 32'sd0;
      end
      default: begin
      end
    endcase
  end

  // Control, configuration and animation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      mode_q        <= 4'd0;
      amp_q         <= 32'sd32768;
      accel_q       <= 24'sd0;
      offset_q      <= 32'sd0;
      periods_q     <= 24'sd65536;
      quant_q       <= 16'd0;
      timer_q       <= 32'd0;
      speed_q       <= 24'sd65536;
      delay_q       <= 33'sd0;
    end else begin
      state_q <= state_d;
      timer_q <= timer_d;
      speed_q <= speed_d;
      delay_q <= delay_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_MODE:        mode_q <= cfg_data_i[3:0];
          REG_AMPLITUDE:   amp_q <= cfg_data_i;
          REG_START_SPEED: begin
            speed_q       <= cfg_data_i[23:0];
          end
          REG_ACCEL:       accel_q <= cfg_data_i[23:0];
          REG_OFFSET:      offset_q <= cfg_data_i;
          REG_PERIODS:     periods_q <= cfg_data_i[23:0];
          REG_START_DELAY: begin
            delay_q       <= {1'b0, cfg_data_i};
          end
          REG_QUANT_STEP:  quant_q <= cfg_data_i[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Item capture and working registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dt_q  <= s_axis_tdata_i[15:0];
      en_q  <= s_axis_tdata_i[16];
      ptr_q <= s_axis_tdata_i[17];
      cur_q <= s_axis_tdata_i[49:18];
    end
    before_q <= before_d;
    ended_q  <= ended_d;
    moving_q <= moving_d;
    dteff_q  <= dteff_d;
    pend_q   <= pend_d;
    expt_q   <= expt_d;
    expout_q <= expout_d;
    write_q  <= write_d;
    p_q      <= p_d;
    xmag_q   <= xmag_d;
    xneg_q   <= xneg_d;
    lo_q     <= lo_d;
    sum_q    <= sum_d;
    div_q    <= div_d;
    rem_q    <= rem_d;
    cnt_q    <= cnt_d;
    value_q  <= value_d;
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o)
    else $error("input taken while an item is in work");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[32]) |-> (m_axis_tdata_o[31:0] == 32'd0))
    else $error("value nonzero without write");

  a_ended_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[33]) |-> m_axis_tdata_o[32])
    else $error("delay end without write");

endmodule

// File: design/twg_mul.sv
// Shared registered unsigned multiplier used by the multiplying steps of the sequencer.
module twg_mul import twg_pkg::*; (
  input  logic               clk_i,
  input  mul_req_t           req_i,
  output logic [MUL_P_W-1:0] prod_o
);

  // Multiply and register the product when a step asks for it
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_o <= MUL_P_W'(req_i.a) * MUL_P_W'(req_i.b);
    end
  end

endmodule
